[rtl/ssba_pkg.sv]
// ----------------------------------------------------------------------------
// ssba_pkg
// Shared constants and codes for the swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package ssba_pkg;

  // Geometry of the slot bitmap.
  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;
  localparam int WORD_W           = 32;
  localparam int WORDS            = MAX_SLOTS / WORD_W;
  localparam int WADDR_W          = $clog2(WORDS);
  localparam int BIT_W            = $clog2(WORD_W);
  localparam int SLOT_W           = $clog2(MAX_SLOTS);
  localparam int SPS_SHIFT        = $clog2(SECTORS_PER_SLOT);

  // Field and register widths.
  localparam int SECTOR_W = 13;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(1024);

  // Register index of slot_count within the register map.
  localparam logic REG_SLOT_COUNT = 1'b0;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

[rtl/ssba_ram.sv]
// ----------------------------------------------------------------------------
// ssba_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ssba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/swap_slot_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator
// First-fit allocator over a bitmap of swap slots, one used bit per slot.
//
//   Channel  Direction  Beat contents             Handshake
//   in       input      op_i, sector_i            in_valid_i / in_stall_o
//   out      output     status_o, alloc_sector_o  out_valid_o / out_stall_i
//   config   input      slot_count at address 0   APB (psel, penable, ...)
//
// An item passes in order through accept and word read, evaluate and write
// back, then the load of the output register. The registered read of the
// bitmap word memory is why these steps are separate. A summary of full words
// in flip-flops picks the word to read, so allocation never scans the memory.
// Reset clears the summary and the per-word valid bits at once; no clearing pass is needed.
// A stalled output holds the third step until the result register is free.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator
  import ssba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [SECTOR_W-1:0] sector_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SECTOR_W-1:0] alloc_sector_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     slot_count_q;
  logic [CNT_W-1:0]     limit;
  logic [WORDS-1:0]     full_q, vld_q;
  logic                 op_q;
  logic [WADDR_W-1:0]   waddr_q;
  logic [BIT_W-1:0]     bit_q;
  logic                 in_range_q;
  logic                 none_q;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [SECTOR_W-1:0]  res_sector_q, res_sector_d;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [SECTOR_W-1:0]  out_sector_q;

  logic                 in_accept;
  logic                 out_free;
  logic [WADDR_W-1:0]   alloc_word;
  logic [SECTOR_W-1:0]  free_slot;
  logic [WADDR_W-1:0]   acc_waddr;
  logic                 acc_in_range;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    word;
  logic [BIT_W-1:0]     zero_bit;
  logic [SLOT_W-1:0]    alloc_slot;
  logic                 alloc_ok, free_ok;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 cfg_write;

  // Handshakes.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration register; the effective count is capped at the slot total.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SLOT_COUNT);
  assign prdata    = (paddr[2] == REG_SLOT_COUNT) ? DATA_W'(slot_count_q) : '0;
  assign limit     = (slot_count_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RESET;
    end else if (cfg_write) begin
      slot_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Lowest word that still has a free bit, taken from the full summary.
  always_comb begin
    alloc_word = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        alloc_word = WADDR_W'(i);
      end
    end
  end

  // Slot addressed by a free request, and the word to read at accept.
  assign free_slot    = sector_i >> SPS_SHIFT;
  assign acc_in_range = free_slot < SECTOR_W'(limit);
  assign acc_waddr    = (op_i == OP_FREE) ? free_slot[SLOT_W-1:BIT_W] : alloc_word;

  ssba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_q),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (acc_waddr),
    .rdata_o (ram_rdata)
  );

  // A word never written reads as all free.
  assign word = vld_q[waddr_q] ? ram_rdata : '0;

  // Lowest free bit in the word that was read.
  always_comb begin
    zero_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zero_bit = BIT_W'(i);
      end
    end
  end

  assign alloc_slot = {waddr_q, zero_bit};
  assign alloc_ok   = !none_q && (CNT_W'(alloc_slot) < limit);
  assign free_ok    = in_range_q && word[bit_q];

  // Read-modify-write of the bitmap word.
  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = word;
    res_status_d = res_status_q;
    res_sector_d = res_sector_q;
    if (state_q == S_EVAL) begin
      res_sector_d = '0;
      if (op_q == OP_ALLOC) begin
        if (alloc_ok) begin
          ram_we       = 1'b1;
          ram_wdata    = word | (WORD_W'(1) << zero_bit);
          res_status_d = ST_OK;
          res_sector_d = SECTOR_W'(32'(alloc_slot) * SECTORS_PER_SLOT);
        end else begin
          res_status_d = ST_FULL;
        end
      end else begin
        if (free_ok) begin
          ram_we       = 1'b1;
          ram_wdata    = word & ~(WORD_W'(1) << bit_q);
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_BAD_FREE;
        end
      end
    end
  end

  // Full summary and written-word flags follow every write back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
      vld_q  <= '0;
    end else if (ram_we) begin
      full_q[waddr_q] <= &ram_wdata;
      vld_q[waddr_q]  <= 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_accept) state_d = S_EVAL;
      S_EVAL: state_d = S_RESP;
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state, request capture and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      op_q         <= OP_ALLOC;
      waddr_q      <= '0;
      bit_q        <= '0;
      in_range_q   <= 1'b0;
      none_q       <= 1'b0;
      res_status_q <= ST_OK;
      res_sector_q <= '0;
      out_status_q <= ST_OK;
      out_sector_q <= '0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_sector_q <= res_sector_d;
      if (in_accept) begin
        op_q       <= op_i;
        waddr_q    <= acc_waddr;
        bit_q      <= free_slot[BIT_W-1:0];
        in_range_q <= acc_in_range;
        none_q     <= &full_q;
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_sector_q <= res_sector_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign alloc_sector_o = out_sector_q;

endmodule

[rtl/ssba_checker.sv]
// ----------------------------------------------------------------------------
// ssba_checker
// Port-level checks for the swap slot bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
module ssba_checker
  import ssba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                op_i,
  input logic [SECTOR_W-1:0] sector_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [SECTOR_W-1:0] alloc_sector_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [PADDR_W-1:0]  paddr,
  input logic [DATA_W-1:0]   pwdata,
  input logic [DATA_W-1:0]   prdata,
  input logic                pready
);

  // Only one request is in flight: an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a request was in flight");

  // A failed result never carries a sector.
  a_sector_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> alloc_sector_o == '0)
    else $error("nonzero sector on an error result");

  // Only the three defined status codes ever appear on a result beat.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_FULL || status_o == ST_BAD_FREE)
    else $error("illegal status code");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(alloc_sector_o))
    else $error("stalled result beat changed");

endmodule

bind swap_slot_bitmap_allocator ssba_checker u_ssba_checker (.*);
